// ===== design/ffba_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
// No dependencies; used by scoped name by the top level, ffba_ctrl and ffba_checker.
package ffba_pkg;

  localparam int unsigned MAX_BLOCKS = 64;
  localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned SZ_W       = 33;

  localparam logic [SZ_W-1:0] HEADER_BYTES = 33'd32;
  localparam logic [SZ_W-1:0] ALIGN_MASK   = 33'd15;
  localparam logic [SZ_W-1:0] SPLIT_LIMIT  = 33'd48;  // header plus minimum split payload
  localparam logic [SZ_W-1:0] ARENA_RESET  = 33'd33554432;
  localparam logic [SZ_W-1:0] ARENA_LIMIT  = 33'h1_0000_0000;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_ZERO    = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic            free;
    logic [SZ_W-1:0] size;
    logic [SZ_W-1:0] start;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [1:0]      status;
    logic [31:0]     address_out;
    logic [SZ_W-1:0] granted_size;
    logic [SZ_W-1:0] in_use_bytes;
    logic [SZ_W-1:0] largest_free;
  } result_t;

endpackage

// ===== design/first_fit_block_allocator.sv =====
// First-fit block allocator top level: stream ports, config register, result register.
// Depends on ffba_pkg and ffba_ctrl.
//
// Usage: one request beat on s_axis (op, size, address) gives exactly one result
// beat on m_axis (status, address_out, granted_size, in_use_bytes, largest_free).
// op 0 allocates size bytes rounded up to 16 from the first free block that fits;
// op 1 frees the block whose payload starts at address and merges free neighbors.
// The block table (64 entries) sits in a single-port-read RAM and one sequencer
// walks it in passes: a scan for the hit, an optional shift pass to insert or
// remove entries, and a pass for the largest free block. s_axis_tready is low
// while an item is in progress and rises in the same cycle that the result
// appears in the output register.
// The result sits in that register; the next request is taken while it
// waits, and a stalled receiver holds the sequencer only at its final step.
// Reset and any write of arena_bytes (APB, 8-byte register at address 0) rebuild
// the table as one free block and clear the used count.
module first_fit_block_allocator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // op[0], size[32:1], address[64:33], zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], address_out[33:2], granted_size[66:34], in_use_bytes[99:67],
  // largest_free[132:100], zero pad
  output logic [135:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  logic [ffba_pkg::SZ_W-1:0] arena_q;
  logic                      cfg_wr;
  logic                      res_valid, res_ready;
  ffba_pkg::result_t         res;
  logic                      out_valid_q;
  ffba_pkg::result_t         out_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[3] == 1'b0);
  assign prdata = {31'd0, arena_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q <= ffba_pkg::ARENA_RESET;
    end else if (cfg_wr) begin
      arena_q <= (pwdata[32:0] > ffba_pkg::ARENA_LIMIT) ? ffba_pkg::ARENA_LIMIT : pwdata[32:0];
    end
  end

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_i      (cfg_wr),
    .arena_i     (arena_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tdata[0]),
    .size_i      (s_axis_tdata[32:1]),
    .addr_i      (s_axis_tdata[64:33]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_q.largest_free, out_q.in_use_bytes, out_q.granted_size,
                          out_q.address_out, out_q.status};

endmodule

// ===== design/ffba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== design/ffba_ctrl.sv =====
// Sequencer and shared datapath: scans, shifts and merges the block table.
// Depends on ffba_pkg and ffba_ram.
module ffba_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    init_i,
  input  logic [ffba_pkg::SZ_W-1:0] arena_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    op_i,
  input  logic [31:0]             size_i,
  input  logic [31:0]             addr_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output ffba_pkg::result_t       res_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_SRD  = 4'd2;
  localparam logic [3:0] S_SCK  = 4'd3;
  localparam logic [3:0] S_IRD  = 4'd4;
  localparam logic [3:0] S_IWR  = 4'd5;
  localparam logic [3:0] S_INEW = 4'd6;
  localparam logic [3:0] S_HWR  = 4'd7;
  localparam logic [3:0] S_NRD  = 4'd8;
  localparam logic [3:0] S_NCK  = 4'd9;
  localparam logic [3:0] S_FWR  = 4'd10;
  localparam logic [3:0] S_DRD  = 4'd11;
  localparam logic [3:0] S_DWR  = 4'd12;
  localparam logic [3:0] S_LRD  = 4'd13;
  localparam logic [3:0] S_LCK  = 4'd14;
  localparam logic [3:0] S_FIN  = 4'd15;

  localparam int unsigned IW = ffba_pkg::IDX_W;
  localparam int unsigned CW = ffba_pkg::CNT_W;
  localparam int unsigned SW = ffba_pkg::SZ_W;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [IW-1:0] hit_q, hit_d;
  logic [1:0]    rm_q, rm_d;
  logic          op_q, op_d;
  logic          split;
  logic          nf_q, nf_d;
  logic [SW-1:0] req_q, req_d;
  logic [31:0]   addr_q, addr_d;
  logic [SW-1:0] used_q, used_d;
  logic [SW-1:0] best_q, best_d;
  logic [SW-1:0] msize_q, msize_d;
  logic [1:0]    status_q, status_d;
  logic [31:0]   aout_q, aout_d;
  logic [SW-1:0] gsize_q, gsize_d;
  ffba_pkg::entry_t hit_e_q, hit_e_d, prev_e_q, prev_e_d;

  logic                we, re;
  logic [IW-1:0]       waddr, raddr;
  ffba_pkg::entry_t    wdata, rdata;

  ffba_ram #(
    .WIDTH (ffba_pkg::ENTRY_W),
    .DEPTH (ffba_pkg::MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // shared arithmetic terms
  logic [SW-1:0] rest;
  logic          hit_match;
  logic [CW-1:0] hit_p1;
  logic          pf;
  logic [IW-1:0] tgt;
  logic [CW-1:0] tgt_src;
  logic [1:0]    rm_now;

  always_comb begin
    rest      = rdata.size - req_q;
    if (op_q == ffba_pkg::OP_FREE) begin
      hit_match = ({1'b0, rdata.start} + {1'b0, ffba_pkg::HEADER_BYTES}) == {2'b00, addr_q};
    end else begin
      hit_match = rdata.free && (rdata.size >= req_q);
    end
    hit_p1  = {1'b0, hit_q} + CW'(1);
    pf      = (hit_q != '0) && prev_e_q.free;
    tgt     = pf ? hit_q - IW'(1) : hit_q;
    rm_now  = {1'b0, pf} + {1'b0, nf_q};
    tgt_src = {1'b0, tgt} + CW'(1) + CW'(rm_now);
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    hit_d    = hit_q;
    rm_d     = rm_q;
    op_d     = op_q;
    split    = 1'b0;
    nf_d     = nf_q;
    req_d    = req_q;
    addr_d   = addr_q;
    used_d   = used_q;
    best_d   = best_q;
    msize_d  = msize_q;
    status_d = status_q;
    aout_d   = aout_q;
    gsize_d  = gsize_q;
    hit_e_d  = hit_e_q;
    prev_e_d = prev_e_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = idx_q[IW-1:0];
    raddr    = idx_q[IW-1:0];
    wdata    = rdata;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d     = op_i;
          req_d    = ({1'b0, size_i} + ffba_pkg::ALIGN_MASK) & ~ffba_pkg::ALIGN_MASK;
          addr_d   = addr_i;
          status_d = ffba_pkg::ST_OK;
          aout_d   = '0;
          gsize_d  = '0;
          idx_d    = '0;
          if (op_i == ffba_pkg::OP_ALLOC && size_i == '0) begin
            status_d = ffba_pkg::ST_ZERO;
            best_d   = '0;
            state_d  = S_LRD;
          end else begin
            state_d = S_SRD;
          end
        end
      end
      S_INIT: begin
        we          = 1'b1;
        waddr       = '0;
        wdata.free  = 1'b1;
        wdata.start = '0;
        wdata.size  = (arena_i >= ffba_pkg::HEADER_BYTES) ?
                      arena_i - ffba_pkg::HEADER_BYTES : '0;
        cnt_d       = CW'(1);
        used_d      = '0;
        state_d     = S_IDLE;
      end
      S_SRD: begin
        re      = 1'b1;
        state_d = S_SCK;
      end
      S_SCK: begin
        if (hit_match) begin
          hit_d   = idx_q[IW-1:0];
          hit_e_d = rdata;
          if (op_q == ffba_pkg::OP_ALLOC) begin
            split   = (rest > ffba_pkg::SPLIT_LIMIT) && (cnt_q < CW'(ffba_pkg::MAX_BLOCKS));
            gsize_d = split ? req_q : rdata.size;
            aout_d  = 32'(rdata.start + ffba_pkg::HEADER_BYTES);
            used_d  = used_q + gsize_d;
            idx_d   = cnt_q;
            if (!split) begin
              state_d = S_HWR;
            end else if (cnt_q > idx_q + CW'(1)) begin
              state_d = S_IRD;
            end else begin
              state_d = S_INEW;
            end
          end else begin
            gsize_d = rdata.size;
            aout_d  = addr_q;
            msize_d = rdata.size;
            nf_d    = 1'b0;
            if (!rdata.free) begin
              used_d = (used_q >= rdata.size) ? used_q - rdata.size : '0;
            end
            if (idx_q + CW'(1) < cnt_q) begin
              idx_d   = idx_q + CW'(1);
              state_d = S_NRD;
            end else begin
              state_d = S_FWR;
            end
          end
        end else begin
          prev_e_d = rdata;
          if (idx_q + CW'(1) == cnt_q) begin
            status_d = (op_q == ffba_pkg::OP_FREE) ? ffba_pkg::ST_UNKNOWN : ffba_pkg::ST_NOFIT;
            idx_d    = '0;
            best_d   = '0;
            state_d  = S_LRD;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = S_SRD;
          end
        end
      end
      S_IRD: begin
        re      = 1'b1;
        raddr   = IW'(idx_q - CW'(1));
        state_d = S_IWR;
      end
      S_IWR: begin
        we    = 1'b1;
        idx_d = idx_q - CW'(1);
        state_d = (idx_d > hit_p1) ? S_IRD : S_INEW;
      end
      S_INEW: begin
        we          = 1'b1;
        waddr       = hit_p1[IW-1:0];
        wdata.free  = 1'b1;
        wdata.size  = hit_e_q.size - req_q - ffba_pkg::HEADER_BYTES;
        wdata.start = hit_e_q.start + ffba_pkg::HEADER_BYTES + req_q;
        cnt_d       = cnt_q + CW'(1);
        state_d     = S_HWR;
      end
      S_HWR: begin
        we          = 1'b1;
        waddr       = hit_q;
        wdata.free  = 1'b0;
        wdata.size  = gsize_q;
        wdata.start = hit_e_q.start;
        idx_d       = '0;
        best_d      = '0;
        state_d     = S_LRD;
      end
      S_NRD: begin
        re      = 1'b1;
        state_d = S_NCK;
      end
      S_NCK: begin
        nf_d = rdata.free;
        if (rdata.free) begin
          msize_d = hit_e_q.size + ffba_pkg::HEADER_BYTES + rdata.size;
        end
        state_d = S_FWR;
      end
      S_FWR: begin
        we          = 1'b1;
        waddr       = tgt;
        wdata.free  = 1'b1;
        wdata.size  = pf ? prev_e_q.size + ffba_pkg::HEADER_BYTES + msize_q : msize_q;
        wdata.start = pf ? prev_e_q.start : hit_e_q.start;
        rm_d        = rm_now;
        idx_d       = tgt_src;
        if (tgt_src < cnt_q) begin
          state_d = S_DRD;
        end else begin
          cnt_d   = cnt_q - CW'(rm_now);
          idx_d   = '0;
          best_d  = '0;
          state_d = S_LRD;
        end
      end
      S_DRD: begin
        re      = 1'b1;
        state_d = S_DWR;
      end
      S_DWR: begin
        we    = 1'b1;
        waddr = IW'(idx_q - CW'(rm_q));
        if (idx_q + CW'(1) < cnt_q) begin
          idx_d   = idx_q + CW'(1);
          state_d = S_DRD;
        end else begin
          cnt_d   = cnt_q - CW'(rm_q);
          idx_d   = '0;
          best_d  = '0;
          state_d = S_LRD;
        end
      end
      S_LRD: begin
        re      = 1'b1;
        state_d = S_LCK;
      end
      S_LCK: begin
        if (rdata.free && rdata.size > best_q) begin
          best_d = rdata.size;
        end
        if (idx_q + CW'(1) >= cnt_q) begin
          state_d = S_FIN;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_LRD;
        end
      end
      S_FIN: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // arena rewrite rebuilds the table
    if (init_i) begin
      state_d = S_INIT;
      cnt_d   = CW'(1);
      used_d  = '0;
    end
  end

  assign res_o.status       = status_q;
  assign res_o.address_out  = aout_q;
  assign res_o.granted_size = gsize_q;
  assign res_o.in_use_bytes = used_q;
  assign res_o.largest_free = best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q   <= CW'(1);
      used_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      used_q  <= used_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q    <= hit_d;
    rm_q     <= rm_d;
    op_q     <= op_d;
    nf_q     <= nf_d;
    req_q    <= req_d;
    addr_q   <= addr_d;
    best_q   <= best_d;
    msize_q  <= msize_d;
    status_q <= status_d;
    aout_q   <= aout_d;
    gsize_q  <= gsize_d;
    hit_e_q  <= hit_e_d;
    prev_e_q <= prev_e_d;
  end

endmodule

// ===== design/ffba_checker.sv =====
// Port-level checks for the first-fit block allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_allocator.
module ffba_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);

  logic [1:0] status;
  assign status = m_axis_tdata[1:0];

  // sequencer takes one request at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while sequencer busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status != ffba_pkg::ST_OK |->
      m_axis_tdata[33:2] == '0 && m_axis_tdata[66:34] == '0)
    else $error("failed beat carries address or size");

  a_ok_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == ffba_pkg::ST_OK |-> m_axis_tdata[33:2] != '0)
    else $error("granted payload offset is zero");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/tb_first_fit_block_allocator.sv =====
// Testbench for first_fit_block_allocator: directed and random allocate/free traffic with
// an in-bench table predictor, scoreboarded per result beat. Needs ffba_pkg and the design.
`timescale 1ns / 1ps
module tb_first_fit_block_allocator;

  localparam int          TBL       = ffba_pkg::MAX_BLOCKS;
  localparam longint      HDR       = ffba_pkg::HEADER_BYTES;
  localparam longint      SPLIT     = ffba_pkg::SPLIT_LIMIT;
  localparam int          SZW       = ffba_pkg::SZ_W;
  localparam longint      CYC_LIMIT = 6000000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;

  first_fit_block_allocator dut (.*);

  always #5 clk_i = ~clk_i;

  // table mirror
  longint unsigned arena_sz;
  longint unsigned blk_start [TBL];
  longint unsigned blk_size  [TBL];
  bit              blk_free  [TBL];
  int              blk_cnt;
  longint unsigned used_sum;

  ffba_pkg::result_t pending_q[$];
  longint unsigned live_addr[$];
  int              err_cnt = 0;
  longint          cycles = 0;
  bit              no_idle = 1'b0;

  function automatic void rebuild_table();
    for (int i = 0; i < TBL; i++) begin
      blk_start[i] = 0; blk_size[i] = 0; blk_free[i] = 0;
    end
    blk_size[0] = (arena_sz >= HDR) ? arena_sz - HDR : 0;
    blk_free[0] = 1;
    blk_cnt     = 1;
    used_sum    = 0;
  endfunction

  function automatic void drop_entry(int idx);
    for (int i = idx; i + 1 < blk_cnt; i++) begin
      blk_start[i] = blk_start[i+1]; blk_size[i] = blk_size[i+1]; blk_free[i] = blk_free[i+1];
    end
    blk_cnt--;
    blk_start[blk_cnt] = 0; blk_size[blk_cnt] = 0; blk_free[blk_cnt] = 0;
  endfunction

  function automatic void join_next(int idx);
    while (idx + 1 < blk_cnt && blk_free[idx+1]) begin
      blk_size[idx] = (blk_size[idx] + HDR + blk_size[idx+1]) & 64'h1_FFFF_FFFF;
      drop_entry(idx + 1);
    end
  endfunction

  function automatic void coalesce(int idx);
    if (!blk_free[idx]) return;
    join_next(idx);
    while (idx > 0 && blk_free[idx-1]) begin
      blk_size[idx-1] = (blk_size[idx-1] + HDR + blk_size[idx]) & 64'h1_FFFF_FFFF;
      drop_entry(idx);
      idx--;
      join_next(idx);
    end
  endfunction

  function automatic ffba_pkg::result_t predict_alloc_free(bit op, longint unsigned sz,
                                                           longint unsigned adr);
    ffba_pkg::result_t r;
    longint unsigned req, rest, best;
    int hit;
    r = '0;
    hit = -1;
    if (op == ffba_pkg::OP_ALLOC) begin
      if (sz == 0) r.status = ffba_pkg::ST_ZERO;
      else begin
        req = ((sz + 15) >> 4) << 4;
        for (int i = 0; i < blk_cnt; i++)
          if (hit < 0 && blk_free[i] && blk_size[i] >= req) hit = i;
        if (hit < 0) r.status = ffba_pkg::ST_NOFIT;
        else begin
          rest = blk_size[hit] - req;
          if (rest > SPLIT && blk_cnt < TBL) begin
            for (int i = blk_cnt; i > hit + 1; i--) begin
              blk_start[i] = blk_start[i-1]; blk_size[i] = blk_size[i-1];
              blk_free[i] = blk_free[i-1];
            end
            blk_start[hit+1] = blk_start[hit] + HDR + req;
            blk_size[hit+1]  = rest - HDR;
            blk_free[hit+1]  = 1;
            blk_cnt++;
            blk_size[hit] = req;
          end
          blk_free[hit] = 0;
          used_sum = (used_sum + blk_size[hit]) & 64'h1_FFFF_FFFF;
          r.status       = ffba_pkg::ST_OK;
          r.address_out  = 32'(blk_start[hit] + HDR);
          r.granted_size = SZW'(blk_size[hit]);
          live_addr.push_back((blk_start[hit] + HDR) & 64'hFFFF_FFFF);
        end
      end
    end else begin
      for (int i = 0; i < blk_cnt; i++)
        if (hit < 0 && blk_start[i] + HDR == adr) hit = i;
      if (hit < 0) r.status = ffba_pkg::ST_UNKNOWN;
      else begin
        r.status       = ffba_pkg::ST_OK;
        r.granted_size = SZW'(blk_size[hit]);
        r.address_out  = 32'(adr);
        if (!blk_free[hit]) begin
          blk_free[hit] = 1;
          used_sum = (used_sum >= blk_size[hit]) ? used_sum - blk_size[hit] : 0;
        end
        coalesce(hit);
        for (int i = live_addr.size() - 1; i >= 0; i--)
          if (live_addr[i] == adr) live_addr.delete(i);
      end
    end
    best = 0;
    for (int i = 0; i < blk_cnt; i++)
      if (blk_free[i] && blk_size[i] > best) best = blk_size[i];
    r.in_use_bytes = SZW'(used_sum);
    r.largest_free = SZW'(best);
    return r;
  endfunction

  function automatic int idle_gap();
    if (no_idle || $urandom_range(0, 99) >= 36) return 0;
    return $urandom_range(1, 5);
  endfunction

  task automatic send_req(bit op, longint unsigned sz, longint unsigned adr);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {7'b0, adr[31:0], sz[31:0], op};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.push_back(predict_alloc_free(op, sz[31:0], adr[31:0]));
  endtask

  task automatic drain();
    @(negedge clk_i) s_axis_tvalid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_arena(longint unsigned val);
    drain();
    psel = 1'b1; pwrite = 1'b1; paddr = '0; pwdata = val;
    @(negedge clk_i) penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    val &= 64'h1_FFFF_FFFF;
    arena_sz = (val > 64'h1_0000_0000) ? 64'h1_0000_0000 : val;
    rebuild_table();
    live_addr.delete();
  endtask

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    err_cnt++;
  endtask

  // result side
  always @(negedge clk_i)
    m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 36);

  always @(posedge clk_i) begin
    ffba_pkg::result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) report_mismatch("unexpected result beat", m_axis_tdata[1:0], 0);
      else begin
        want = pending_q.pop_front();
        if (m_axis_tdata[1:0] != want.status)
          report_mismatch("status", m_axis_tdata[1:0], want.status);
        if (m_axis_tdata[33:2] != want.address_out)
          report_mismatch("address_out", m_axis_tdata[33:2], want.address_out);
        if (m_axis_tdata[66:34] != want.granted_size)
          report_mismatch("granted_size", m_axis_tdata[66:34], want.granted_size);
        if (m_axis_tdata[99:67] != want.in_use_bytes)
          report_mismatch("in_use_bytes", m_axis_tdata[99:67], want.in_use_bytes);
        if (m_axis_tdata[132:100] != want.largest_free)
          report_mismatch("largest_free", m_axis_tdata[132:100], want.largest_free);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_basic_ops();
    send_req(ffba_pkg::OP_ALLOC, 0, 0);
    send_req(ffba_pkg::OP_ALLOC, 1, 0);
    send_req(ffba_pkg::OP_ALLOC, 32'hFFFF_FFFF, 0);
    send_req(ffba_pkg::OP_ALLOC, 16, 32'hFFFF_FFFF);
    send_req(ffba_pkg::OP_ALLOC, 100, 0);
    send_req(ffba_pkg::OP_FREE, 0, 32);              // first block, neighbor still used
    send_req(ffba_pkg::OP_FREE, 32'hFFFF_FFFF, 32);  // already free
    send_req(ffba_pkg::OP_FREE, 0, 0);
    send_req(ffba_pkg::OP_FREE, 0, 32'hFFFF_FFFF);
    send_req(ffba_pkg::OP_FREE, 0, 33);
    send_req(ffba_pkg::OP_FREE, 0, 80);
    send_req(ffba_pkg::OP_FREE, 0, 128);
  endtask

  task automatic test_arena_extremes();
    write_arena(64'h1_0000_0000);
    send_req(ffba_pkg::OP_ALLOC, 32'hFFFF_FFF0, 0);
    send_req(ffba_pkg::OP_ALLOC, 32'hFFFF_FFE0, 0);
    send_req(ffba_pkg::OP_FREE, 0, 32);
    write_arena(64'h1_FFFF_FFFF);          // clamped to 4 GiB
    send_req(ffba_pkg::OP_ALLOC, 1, 0);
    write_arena(16);                       // smaller than a header
    send_req(ffba_pkg::OP_ALLOC, 1, 0);
    send_req(ffba_pkg::OP_FREE, 0, 32);
    write_arena(0);
    send_req(ffba_pkg::OP_ALLOC, 16, 0);
    write_arena(4096);
    send_req(ffba_pkg::OP_ALLOC, 4064, 0);
    send_req(ffba_pkg::OP_ALLOC, 1, 0);
    send_req(ffba_pkg::OP_FREE, 0, 32);
  endtask

  task automatic test_full_table();
    write_arena(8192);
    for (int i = 0; i < TBL + 1; i++) send_req(ffba_pkg::OP_ALLOC, $urandom_range(1, 16), 0);
    for (int i = 0; i < TBL; i += 2) send_req(ffba_pkg::OP_FREE, 0, 32 + 48 * i);
    for (int i = 1; i < TBL; i += 2) send_req(ffba_pkg::OP_FREE, 0, 32 + 48 * i);
  endtask

  task automatic test_random_traffic();
    longint unsigned arenas[4] = '{4096, 65536, 1 << 20, 33554432};
    int pick;
    longint unsigned sz;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3) begin
        drain();
        rst_ni = 1'b1;  // keep reset deasserted; default arena already rebuilt by writes
      end
      write_arena(arenas[ph]);
      no_idle = (ph == 2);
      for (int n = 0; n < 380; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          sz = $urandom_range(1, 256);
          send_req(ffba_pkg::OP_ALLOC, sz, $urandom);
        end else if (pick < 48) send_req(ffba_pkg::OP_ALLOC, $urandom_range(1, 8192), $urandom);
        else if (pick < 52) send_req(ffba_pkg::OP_ALLOC, $urandom, $urandom);
        else if (pick < 54) send_req(ffba_pkg::OP_ALLOC, 0, $urandom);
        else if (pick < 90 && live_addr.size() != 0)
          send_req(ffba_pkg::OP_FREE, $urandom,
                   live_addr[$urandom_range(0, live_addr.size() - 1)]);
        else if (pick < 95) send_req(ffba_pkg::OP_FREE, $urandom, $urandom);
        else send_req(ffba_pkg::OP_FREE, $urandom, 32 + 16 * $urandom_range(0, 64));
      end
      while (live_addr.size() != 0 && $urandom_range(0, 3) != 0)
        send_req(ffba_pkg::OP_FREE, 0, live_addr[0]);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    arena_sz = 33554432;
    rebuild_table();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    test_basic_ops();
    test_arena_extremes();
    test_full_table();
    test_random_traffic();
    drain();
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
